@@ sv/gamepad_input_qualifier_top_assert.svh @@
// assertion macros shared by the gamepad input qualifier modules
`ifndef GAMEPAD_INPUT_QUALIFIER_TOP_ASSERT_SVH
`define GAMEPAD_INPUT_QUALIFIER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define GPIQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gpiq assertion failed");

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define GPIQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gpiq assertion failed");

`endif

@@ sv/gpiq_pkg.sv @@
// types and constants of the gamepad input qualifier
`default_nettype none

package gpiq_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NAV_HOLDOFF  = 4'd0,
    CFG_STICK_THR    = 4'd1,
    CFG_TRIG_HOLDOFF = 4'd2,
    CFG_TRIG_THR     = 4'd3
  } cfg_index_e;

  localparam logic [15:0] NAV_HOLDOFF_RST  = 16'd200;
  localparam logic [14:0] STICK_THR_RST    = 15'd16000;
  localparam logic [15:0] TRIG_HOLDOFF_RST = 16'd100;
  localparam logic [9:0]  TRIG_THR_RST     = 10'd100;

  // link state
  typedef enum logic [1:0] {
    LINK_DISCONNECTED = 2'd0,
    LINK_SCANNING     = 2'd1,
    LINK_CONNECTED    = 2'd2,
    LINK_ACTIVE       = 2'd3
  } link_state_e;

  // event codes
  localparam logic [3:0] EV_BTN_A     = 4'd0;
  localparam logic [3:0] EV_NAV_LEFT  = 4'd4;
  localparam logic [3:0] EV_TRIG_R    = 4'd8;
  localparam logic [3:0] EV_TRIG_L    = 4'd9;
  localparam logic [3:0] EV_LINK      = 4'd10;

  // pending event slots, emitted lowest first
  localparam int unsigned NUM_SLOTS   = 11;
  localparam int unsigned SLOT_W      = 4;
  localparam logic [SLOT_W-1:0] SLOT_LINK   = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_BTN0   = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_BTN3   = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_NAV0   = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_NAV3   = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_TRIG_R = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_TRIG_L = 4'd10;

  // haptic kinds
  localparam logic [1:0] HAPTIC_NONE  = 2'd0;
  localparam logic [1:0] HAPTIC_TICK  = 2'd1;
  localparam logic [1:0] HAPTIC_SHORT = 2'd2;

  // arithmetic constants
  localparam logic [15:0] AXIS_FLIP  = 16'h8000;
  localparam logic [9:0]  TRIG_FULL  = 10'd1023;
  localparam logic [4:0]  INT_BASE   = 5'd5;
  localparam int unsigned INT_SPAN   = 25;
  localparam int unsigned QUOT_W     = 5;
  localparam int unsigned DIV_BIT_W  = $clog2(QUOT_W);
  localparam int unsigned NUM_W      = 15;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PLAN,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_EMIT
  } ctrl_state_e;

  // input item
  typedef struct packed {
    logic        link_up;
    logic        first_report_pending;
    logic [31:0] now_ms;
    logic [15:0] stick_x_raw;
    logic [15:0] stick_y_raw;
    logic [9:0]  trig_l_pos;
    logic [9:0]  trig_r_pos;
    logic [3:0]  dpad_bits;
    logic [3:0]  button_bits;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [3:0] event_code;
    logic [4:0] intensity;
    logic [1:0] haptic_kind;
    logic [1:0] link_state_out;
    logic       last_of_run;
  } out_item_t;

  // configuration registers
  typedef struct packed {
    logic [15:0] nav_holdoff_ms;
    logic [14:0] stick_threshold;
    logic [15:0] trigger_holdoff_ms;
    logic [9:0]  trig_thr;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic                 capture;
    logic                 eval;
    logic                 div_load;
    logic                 div_step;
    logic                 div_last;
    logic                 div_sel;
    logic [DIV_BIT_W-1:0] div_bit;
    logic                 emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ev_pending;
    logic ev_last;
    logic fire_r;
    logic fire_l;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ sv/gamepad_input_qualifier_top.sv @@
// top level of the gamepad input qualifier
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_ready_o   in_data_i (gpiq_pkg::in_item_t)
//  out      output     out_valid_o / out_ready_i out_data_o (gpiq_pkg::out_item_t)
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item at a time: accept, evaluation, planning, then for each trigger that fires a divider
// load plus five divider steps, then the result items through the single output register,
// which emits one result per cycle while the output is not stalled.
// A stalled output holds the sequencer in its emit state; no new item is taken until the
// last result of the current item is in the output register.
// Reset is asynchronous; the link state comes out of reset as scanning, config at defaults.
`default_nettype none

module gamepad_input_qualifier_top #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire gpiq_pkg::in_item_t               in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output gpiq_pkg::out_item_t                   out_data_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [gpiq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [gpiq_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  gpiq_pkg::cfg_t    cfg;
  gpiq_pkg::dp_cmd_t cmd;
  gpiq_pkg::dp_sts_t sts;

  // configuration registers
  gpiq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sequencer
  gpiq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  gpiq_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ sv/gpiq_cfg.sv @@
// configuration registers of the gamepad input qualifier
`default_nettype none

module gpiq_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [gpiq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [gpiq_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output gpiq_pkg::cfg_t                        cfg_o
);

  gpiq_pkg::cfg_t cfg_q;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // register file, masked to each register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nav_holdoff_ms     <= gpiq_pkg::NAV_HOLDOFF_RST;
      cfg_q.stick_threshold    <= gpiq_pkg::STICK_THR_RST;
      cfg_q.trigger_holdoff_ms <= gpiq_pkg::TRIG_HOLDOFF_RST;
      cfg_q.trig_thr           <= gpiq_pkg::TRIG_THR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gpiq_pkg::CFG_NAV_HOLDOFF:  cfg_q.nav_holdoff_ms     <= cfg_data_i[15:0];
        gpiq_pkg::CFG_STICK_THR:    cfg_q.stick_threshold    <= cfg_data_i[14:0];
        gpiq_pkg::CFG_TRIG_HOLDOFF: cfg_q.trigger_holdoff_ms <= cfg_data_i[15:0];
        gpiq_pkg::CFG_TRIG_THR:     cfg_q.trig_thr           <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ sv/gpiq_ctrl.sv @@
// sequencing controller of the gamepad input qualifier
`default_nettype none
`include "gamepad_input_qualifier_top_assert.svh"

module gpiq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire gpiq_pkg::dp_sts_t sts_i,
  output gpiq_pkg::dp_cmd_t      cmd_o
);

  gpiq_pkg::ctrl_state_e               state_q, state_d;
  logic [gpiq_pkg::DIV_BIT_W-1:0]      cnt_q, cnt_d;
  logic                                sel_q, sel_d;
  logic                                div_end, div_exit;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gpiq_pkg::ST_IDLE;
      cnt_q   <= '0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    sel_d        = sel_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.div_sel = sel_q;
    cmd_o.div_bit = cnt_q;
    case (state_q)
      gpiq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = gpiq_pkg::ST_EVAL;
        end
      end
      gpiq_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = gpiq_pkg::ST_PLAN;
      end
      gpiq_pkg::ST_PLAN: begin
        if (sts_i.fire_r) begin
          sel_d   = 1'b0;
          state_d = gpiq_pkg::ST_DIV_LOAD;
        end else if (sts_i.fire_l) begin
          sel_d   = 1'b1;
          state_d = gpiq_pkg::ST_DIV_LOAD;
        end else begin
          state_d = gpiq_pkg::ST_EMIT;
        end
      end
      gpiq_pkg::ST_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = gpiq_pkg::DIV_BIT_W'(gpiq_pkg::QUOT_W - 1);
        state_d        = gpiq_pkg::ST_DIV_STEP;
      end
      gpiq_pkg::ST_DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_last = (cnt_q == '0);
        if (cnt_q == '0) begin
          if (!sel_q && sts_i.fire_l) begin
            sel_d   = 1'b1;
            state_d = gpiq_pkg::ST_DIV_LOAD;
          end else begin
            state_d = gpiq_pkg::ST_EMIT;
          end
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      gpiq_pkg::ST_EMIT: begin
        if (!sts_i.ev_pending) begin
          state_d = gpiq_pkg::ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.ev_last) begin
            state_d = gpiq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = gpiq_pkg::ST_IDLE;
      end
    endcase
  end

  // last divider step and the states that may follow it
  assign div_end  = (state_q == gpiq_pkg::ST_DIV_STEP) && (cnt_q == '0);
  assign div_exit = (state_q == gpiq_pkg::ST_DIV_LOAD) || (state_q == gpiq_pkg::ST_EMIT);

  // checks
  `GPIQ_ASSERT_IMP(a_idle_no_pending, state_q == gpiq_pkg::ST_IDLE, !sts_i.ev_pending)
  `GPIQ_ASSERT_IMP(a_emit_needs_slot, cmd_o.emit, sts_i.out_free)
  `GPIQ_ASSERT_NXT(a_div_done, div_end, div_exit)

endmodule

`default_nettype wire

@@ sv/gpiq_dp.sv @@
// datapath of the gamepad input qualifier: state, event mask, divider, output register
`default_nettype none
`include "gamepad_input_qualifier_top_assert.svh"

module gpiq_dp #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire gpiq_pkg::dp_cmd_t    cmd_i,
  input  wire gpiq_pkg::cfg_t       cfg_i,
  input  wire gpiq_pkg::in_item_t   in_data_i,
  input  wire logic                 out_ready_i,
  output gpiq_pkg::dp_sts_t         sts_o,
  output logic                      out_valid_o,
  output gpiq_pkg::out_item_t       out_data_o
);

  localparam int unsigned NOW_EXT_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  // directions held: bit0 left, bit1 right, bit2 up, bit3 down
  function automatic logic [3:0] nav_held(input logic [15:0] sx, input logic [15:0] sy,
                                          input logic [3:0] dpad, input logic [14:0] thr);
    logic signed [16:0] ax;
    logic signed [16:0] ay;
    logic signed [16:0] tp;
    logic signed [16:0] tn;
    logic [3:0]         m;
    ax   = signed'({sx[15], sx});
    ay   = signed'({sy[15], sy});
    tp   = signed'({2'b00, thr});
    tn   = -tp;
    m[0] = (ax < tn) || dpad[0];
    m[1] = (ax > tp) || dpad[1];
    m[2] = (ay < tn) || dpad[2];
    m[3] = (ay > tp) || dpad[3];
    return m;
  endfunction

  gpiq_pkg::in_item_t                item_q;
  gpiq_pkg::link_state_e             link_q, link_nx;
  logic [3:0]                        prev_btn_q;
  logic [15:0]                       prev_sx_q, prev_sy_q;
  logic [3:0]                        prev_dpad_q;
  logic [TIME_WIDTH-1:0]             nav_time_q, trig_time_q;
  logic [gpiq_pkg::NUM_SLOTS-1:0]    mask_q, mask_nx;
  logic [gpiq_pkg::NUM_W-1:0]        rem_q;
  logic [gpiq_pkg::QUOT_W-1:0]       quot_q, quot_nx;
  logic [4:0]                        int_r_q, int_l_q;
  logic                              out_valid_q;
  gpiq_pkg::out_item_t               out_q;

  logic                              link_chg, active;
  logic [NOW_EXT_W-1:0]              now_ext;
  logic [TIME_WIDTH-1:0]             now_t;
  logic                              nav_ok, trig_ok;
  logic [15:0]                       sx, sy;
  logic [3:0]                        btn_rise, nav_cur, nav_was, nav_rise;
  logic                              fire_r, fire_l;
  logic [9:0]                        trig_v, trig_diff, div_d;
  logic [gpiq_pkg::NUM_W-1:0]        num, div_sh;
  logic                              div_ge;
  logic [gpiq_pkg::SLOT_W-1:0]       slot;
  gpiq_pkg::out_item_t               res;

  // link update
  always_comb begin
    link_nx  = link_q;
    link_chg = 1'b0;
    if (item_q.link_up) begin
      if ((link_q != gpiq_pkg::LINK_ACTIVE) && !item_q.first_report_pending) begin
        link_nx  = gpiq_pkg::LINK_ACTIVE;
        link_chg = 1'b1;
      end else if ((link_q == gpiq_pkg::LINK_DISCONNECTED) ||
                   (link_q == gpiq_pkg::LINK_SCANNING)) begin
        link_nx  = gpiq_pkg::LINK_CONNECTED;
        link_chg = 1'b1;
      end
    end else if ((link_q == gpiq_pkg::LINK_CONNECTED) || (link_q == gpiq_pkg::LINK_ACTIVE)) begin
      link_nx  = gpiq_pkg::LINK_SCANNING;
      link_chg = 1'b1;
    end
  end

  // report qualification
  assign active   = item_q.link_up && (link_nx == gpiq_pkg::LINK_ACTIVE);
  assign now_ext  = NOW_EXT_W'(item_q.now_ms);
  assign now_t    = now_ext[TIME_WIDTH-1:0];
  assign nav_ok   = (now_t - nav_time_q) > TIME_WIDTH'(cfg_i.nav_holdoff_ms);
  assign trig_ok  = (now_t - trig_time_q) > TIME_WIDTH'(cfg_i.trigger_holdoff_ms);
  assign sx       = item_q.stick_x_raw ^ gpiq_pkg::AXIS_FLIP;
  assign sy       = item_q.stick_y_raw ^ gpiq_pkg::AXIS_FLIP;
  assign btn_rise = item_q.button_bits & ~prev_btn_q;
  assign nav_cur  = nav_held(sx, sy, item_q.dpad_bits, cfg_i.stick_threshold);
  assign nav_was  = nav_held(prev_sx_q, prev_sy_q, prev_dpad_q, cfg_i.stick_threshold);
  assign nav_rise = nav_ok ? (nav_cur & ~nav_was) : 4'b0000;
  assign fire_r   = trig_ok && (item_q.trig_r_pos > cfg_i.trig_thr);
  assign fire_l   = trig_ok && (item_q.trig_l_pos > cfg_i.trig_thr);
  assign mask_nx  = {({fire_l, fire_r, nav_rise, btn_rise} & {10{active}}), link_chg};

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
  end

  // qualifier state and pending event mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q      <= gpiq_pkg::LINK_SCANNING;
      prev_btn_q  <= '0;
      prev_sx_q   <= '0;
      prev_sy_q   <= '0;
      prev_dpad_q <= '0;
      nav_time_q  <= '0;
      trig_time_q <= '0;
      mask_q      <= '0;
    end else if (cmd_i.eval) begin
      link_q <= link_nx;
      mask_q <= mask_nx;
      if (active) begin
        prev_btn_q  <= item_q.button_bits;
        prev_sx_q   <= sx;
        prev_sy_q   <= sy;
        prev_dpad_q <= item_q.dpad_bits;
        if (nav_rise != 4'b0000) begin
          nav_time_q <= now_t;
        end
        if (fire_r || fire_l) begin
          trig_time_q <= now_t;
        end
      end
    end else if (cmd_i.emit) begin
      // retire the lowest pending slot
      mask_q <= mask_q & (mask_q - 1'b1);
    end
  end

  // trigger intensity divider, one quotient bit per step
  assign trig_v    = cmd_i.div_sel ? item_q.trig_l_pos : item_q.trig_r_pos;
  assign trig_diff = trig_v - cfg_i.trig_thr;
  assign num       = gpiq_pkg::NUM_W'(trig_diff) * gpiq_pkg::NUM_W'(gpiq_pkg::INT_SPAN);
  assign div_d     = gpiq_pkg::TRIG_FULL - cfg_i.trig_thr;
  assign div_sh    = gpiq_pkg::NUM_W'(div_d) << cmd_i.div_bit;
  assign div_ge    = rem_q >= div_sh;
  assign quot_nx   = quot_q | (gpiq_pkg::QUOT_W'(div_ge) << cmd_i.div_bit);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q  <= num;
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= rem_q - div_sh;
      end
      quot_q <= quot_nx;
      if (cmd_i.div_last) begin
        if (cmd_i.div_sel) begin
          int_l_q <= quot_nx + gpiq_pkg::INT_BASE;
        end else begin
          int_r_q <= quot_nx + gpiq_pkg::INT_BASE;
        end
      end
    end
  end

  // lowest pending slot
  always_comb begin
    slot = '0;
    for (int i = gpiq_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        slot = gpiq_pkg::SLOT_W'(i);
      end
    end
  end

  // result formatting
  always_comb begin
    res                = '0;
    res.link_state_out = link_q;
    res.last_of_run    = (mask_q & (mask_q - 1'b1)) == '0;
    case (slot) inside
      gpiq_pkg::SLOT_LINK: begin
        res.event_code = gpiq_pkg::EV_LINK;
      end
      [gpiq_pkg::SLOT_BTN0:gpiq_pkg::SLOT_BTN3]: begin
        res.event_code  = slot - gpiq_pkg::SLOT_BTN0 + gpiq_pkg::EV_BTN_A;
        res.haptic_kind = gpiq_pkg::HAPTIC_SHORT;
      end
      [gpiq_pkg::SLOT_NAV0:gpiq_pkg::SLOT_NAV3]: begin
        res.event_code  = slot - gpiq_pkg::SLOT_NAV0 + gpiq_pkg::EV_NAV_LEFT;
        res.haptic_kind = gpiq_pkg::HAPTIC_TICK;
      end
      gpiq_pkg::SLOT_TRIG_R: begin
        res.event_code = gpiq_pkg::EV_TRIG_R;
        res.intensity  = int_r_q;
      end
      gpiq_pkg::SLOT_TRIG_L: begin
        res.event_code = gpiq_pkg::EV_TRIG_L;
        res.intensity  = int_l_q;
      end
      default: begin
        res.event_code = gpiq_pkg::EV_LINK;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;
  assign sts_o.ev_pending = mask_q != '0;
  assign sts_o.ev_last    = (mask_q != '0) && ((mask_q & (mask_q - 1'b1)) == '0);
  assign sts_o.fire_r     = mask_q[gpiq_pkg::SLOT_TRIG_R];
  assign sts_o.fire_l     = mask_q[gpiq_pkg::SLOT_TRIG_L];
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // checks
  `GPIQ_ASSERT_NXT(a_last_clears_mask, cmd_i.emit && sts_o.ev_last, mask_q == '0)

endmodule

`default_nettype wire
